[sv/gbsa_pkg.sv]
// Shared widths, defaults and codes of the grouped bitmap slot allocator.
`timescale 1ns / 1ps

package gbsa_pkg;

  localparam int SLOTS_PER_GROUP_DEF = 64;
  localparam int GROUP_COUNT_DEF = 16;

  localparam int GRP_W = 4;
  localparam int OFF_W = 6;
  localparam int CNT_W = 11;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

endpackage

[sv/gbsa_req_if.sv]
// Request channel of the slot allocator: allocate or free one slot per beat.
`timescale 1ns / 1ps

interface gbsa_req_if;
  logic                           valid;
  logic                           ready;
  gbsa_pkg::req_type_t            req_type;
  logic [gbsa_pkg::GRP_W-1:0]     slot_group;
  logic [gbsa_pkg::OFF_W-1:0]     slot_offset;

  modport source (output valid, req_type, slot_group, slot_offset, input ready);
  modport sink (input valid, req_type, slot_group, slot_offset, output ready);
endinterface

[sv/gbsa_rsp_if.sv]
// Response channel of the slot allocator: one result beat per request.
`timescale 1ns / 1ps

interface gbsa_rsp_if;
  logic                           valid;
  logic                           ready;
  gbsa_pkg::status_t              status;
  logic [gbsa_pkg::GRP_W-1:0]     grant_group;
  logic [gbsa_pkg::OFF_W-1:0]     grant_offset;
  logic [gbsa_pkg::CNT_W-1:0]     free_slots;

  modport source (output valid, status, grant_group, grant_offset, free_slots, input ready);
  modport sink (input valid, status, grant_group, grant_offset, free_slots, output ready);
endinterface

[sv/grouped_bitmap_slot_allocator_core.sv]
// Top level of the grouped bitmap slot allocator: sequencer, state and mask memory.
//
//   Channel  Direction  Beat contents
//   req      in         req_type, slot_group, slot_offset
//   rsp      out        status, grant_group, grant_offset, free_slots
//
// From the accept edge, a free passes S_FREE and a hint hit S_HINT before the response beat
// in S_OUT; a fresh-offset hit passes S_FRESH_RD and S_FRESH, a live-group scan or group
// opening S_FRESH_RD, S_SEARCH and S_SCAN or S_OPEN; a stale hint adds S_HINT and a missed
// fresh slot S_FRESH. Each step is bound by the mask memory's one read port and the shared
// find-first unit. A new request is accepted only after the response beat is taken.
// Reset clears the live flags at once; a dead group's mask reads as all free, so the
// memory needs no clearing pass.
`timescale 1ns / 1ps

module grouped_bitmap_slot_allocator_core #(
  parameter int SLOTS_PER_GROUP = gbsa_pkg::SLOTS_PER_GROUP_DEF,
  parameter int GROUP_COUNT = gbsa_pkg::GROUP_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gbsa_req_if.sink   req,
  gbsa_rsp_if.source rsp
);

  localparam int GW = $clog2(GROUP_COUNT);
  localparam int OW = $clog2(SLOTS_PER_GROUP);
  localparam int FW = $clog2(SLOTS_PER_GROUP + 1);
  localparam int FFW = (GROUP_COUNT > SLOTS_PER_GROUP) ? GROUP_COUNT : SLOTS_PER_GROUP;
  localparam int XW = $clog2(FFW);
  localparam int CW = gbsa_pkg::CNT_W;
  localparam int PW = gbsa_pkg::GRP_W;
  localparam int QW = gbsa_pkg::OFF_W;
  localparam logic [SLOTS_PER_GROUP-1:0] FULL = '1;
  localparam logic [SLOTS_PER_GROUP-1:0] ONE = SLOTS_PER_GROUP'(1);
  localparam logic [CW-1:0] GAIN = CW'(SLOTS_PER_GROUP - 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_HINT     = 9'b000000010,
    S_FRESH_RD = 9'b000000100,
    S_FRESH    = 9'b000001000,
    S_SEARCH   = 9'b000010000,
    S_SCAN     = 9'b000100000,
    S_OPEN     = 9'b001000000,
    S_FREE     = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  state_t                   state;
  logic [GROUP_COUNT-1:0]   live;
  logic [GROUP_COUNT-1:0]   nonempty;
  logic [GW-1:0]            newest_group;
  logic                     newest_valid;
  logic [FW-1:0]            fresh_offset;
  logic                     hint_valid;
  logic [GW-1:0]            hint_group;
  logic [OW-1:0]            hint_offset;
  logic [CW-1:0]            free_count;
  logic [GW-1:0]            cur_grp;
  logic [OW-1:0]            req_off;
  logic                     req_ok;
  gbsa_pkg::status_t        out_status;
  logic [PW-1:0]            out_group;
  logic [QW-1:0]            out_offset;

  logic [GROUP_COUNT-1:0]     dead;
  logic [FFW-1:0]             ffs_vec;
  logic [XW-1:0]              ffs_idx;
  logic                       ffs_hit;
  logic [GW-1:0]              rd_addr;
  logic [SLOTS_PER_GROUP-1:0] ram_rdata;
  logic [SLOTS_PER_GROUP-1:0] mask;
  logic [SLOTS_PER_GROUP-1:0] bitv;
  logic [OW-1:0]              bit_off;
  logic                       live_cur;
  logic                       hit;
  logic                       take;
  logic                       fresh_ok;
  logic                       free_ok;
  logic                       freed_full;
  logic                       ram_we;
  logic [GW-1:0]              ram_waddr;
  logic [SLOTS_PER_GROUP-1:0] ram_wdata;

  assign dead = ~live;

  always_comb begin
    case (state)
      S_SEARCH: ffs_vec = FFW'(nonempty);
      S_OPEN:   ffs_vec = FFW'(dead);
      S_SCAN:   ffs_vec = FFW'(mask);
      default:  ffs_vec = '0;
    endcase
  end

  always_comb begin
    ffs_idx = '0;
    ffs_hit = 1'b0;
    for (int i = FFW - 1; i >= 0; i--) begin
      if (ffs_vec[i]) begin
        ffs_idx = XW'(i);
        ffs_hit = 1'b1;
      end
    end
  end

  always_comb begin
    case (state)
      S_IDLE:     rd_addr = (req.req_type == gbsa_pkg::REQ_FREE) ?
                            GW'(req.slot_group) : hint_group;
      S_FRESH_RD: rd_addr = newest_group;
      S_SEARCH:   rd_addr = GW'(ffs_idx);
      default:    rd_addr = cur_grp;
    endcase
  end

  always_comb begin
    case (state)
      S_HINT:  bit_off = hint_offset;
      S_FRESH: bit_off = OW'(fresh_offset);
      S_SCAN:  bit_off = OW'(ffs_idx);
      S_FREE:  bit_off = req_off;
      default: bit_off = '0;
    endcase
  end

  assign live_cur   = live[cur_grp];
  assign mask       = live_cur ? ram_rdata : FULL;
  assign bitv       = ONE << bit_off;
  assign hit        = |(mask & bitv);
  assign take       = ((state == S_HINT) && live_cur && hit) ||
                      ((state == S_FRESH) && hit) || (state == S_SCAN);
  assign fresh_ok   = newest_valid && (fresh_offset < FW'(SLOTS_PER_GROUP)) &&
                      live[newest_group];
  assign free_ok    = req_ok && live_cur && !hit;
  assign freed_full = ((mask | bitv) == FULL);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_grp;
    ram_wdata = mask & ~bitv;
    if (take) begin
      ram_we = 1'b1;
    end else if (state == S_OPEN) begin
      ram_we    = ffs_hit;
      ram_waddr = GW'(ffs_idx);
      ram_wdata = FULL & ~ONE;
    end else if (state == S_FREE) begin
      ram_we    = free_ok && !freed_full;
      ram_wdata = mask | bitv;
    end
  end

  gbsa_ram #(
    .WIDTH(SLOTS_PER_GROUP),
    .DEPTH(GROUP_COUNT)
  ) u_mask_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    cur_grp <= rd_addr;
    if (rst) begin
      state        <= S_IDLE;
      live         <= '0;
      nonempty     <= '0;
      newest_group <= '0;
      newest_valid <= 1'b0;
      fresh_offset <= FW'(SLOTS_PER_GROUP);
      hint_valid   <= 1'b0;
      hint_group   <= '0;
      hint_offset  <= '0;
      free_count   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_off    <= OW'(req.slot_offset);
            req_ok     <= (32'(req.slot_group) < 32'(GROUP_COUNT)) &&
                          (32'(req.slot_offset) < 32'(SLOTS_PER_GROUP));
            out_status <= gbsa_pkg::ST_OK;
            out_group  <= '0;
            out_offset <= '0;
            if (req.req_type == gbsa_pkg::REQ_FREE) begin
              state <= S_FREE;
            end else if (hint_valid) begin
              state <= S_HINT;
            end else begin
              state <= S_FRESH_RD;
            end
          end
        end
        S_HINT: begin
          hint_valid <= 1'b0;
          state      <= take ? S_OUT : S_FRESH_RD;
        end
        S_FRESH_RD: begin
          state <= fresh_ok ? S_FRESH : S_SEARCH;
        end
        S_FRESH: begin
          fresh_offset <= fresh_offset + FW'(1);
          state        <= take ? S_OUT : S_SEARCH;
        end
        S_SEARCH: begin
          state <= ffs_hit ? S_SCAN : S_OPEN;
        end
        S_SCAN: begin
          state <= S_OUT;
        end
        S_OPEN: begin
          if (ffs_hit) begin
            live[GW'(ffs_idx)]     <= 1'b1;
            nonempty[GW'(ffs_idx)] <= 1'b1;
            newest_group           <= GW'(ffs_idx);
            newest_valid           <= 1'b1;
            fresh_offset           <= FW'(1);
            free_count             <= free_count + GAIN;
            out_group              <= PW'(GW'(ffs_idx));
          end else begin
            out_status <= gbsa_pkg::ST_NO_SLOT;
          end
          state <= S_OUT;
        end
        S_FREE: begin
          if (free_ok) begin
            if (freed_full) begin
              live[cur_grp]     <= 1'b0;
              nonempty[cur_grp] <= 1'b0;
              free_count        <= free_count - GAIN;
              hint_valid        <= 1'b0;
              if (cur_grp == newest_group) begin
                newest_valid <= 1'b0;
                fresh_offset <= FW'(SLOTS_PER_GROUP);
              end
            end else begin
              nonempty[cur_grp] <= 1'b1;
              free_count        <= free_count + CW'(1);
              hint_valid        <= 1'b1;
              hint_group        <= cur_grp;
              hint_offset       <= req_off;
            end
          end else begin
            out_status <= gbsa_pkg::ST_BAD_FREE;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (take) begin
        nonempty[cur_grp] <= |(mask & ~bitv);
        free_count        <= free_count - CW'(1);
        out_group         <= PW'(cur_grp);
        out_offset        <= QW'(bit_off);
      end
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = (state == S_OUT);
  assign rsp.status       = out_status;
  assign rsp.grant_group  = out_group;
  assign rsp.grant_offset = out_offset;
  assign rsp.free_slots   = free_count;

endmodule

[sv/gbsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gbsa_ram #(
  parameter int WIDTH = gbsa_pkg::SLOTS_PER_GROUP_DEF,
  parameter int DEPTH = gbsa_pkg::GROUP_COUNT_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/sv/tb_grouped_bitmap_slot_allocator_core.sv]
// Self-checking regression of the grouped bitmap slot allocator core with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_grouped_bitmap_slot_allocator_core;
  import gbsa_pkg::*;

  localparam int SLOTS = SLOTS_PER_GROUP_DEF;
  localparam int GROUPS = GROUP_COUNT_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {
    FLOW_FREE,
    SENDER_IDLE,
    RECEIVER_STALL,
    BOTH_IDLE
  } idle_mode_t;

  typedef struct {
    status_t          status;
    logic [GRP_W-1:0] grant_group;
    logic [OFF_W-1:0] grant_offset;
    logic [CNT_W-1:0] free_slots;
  } alloc_response_t;

  class slot_allocation_ledger;
    logic [SLOTS-1:0]  mask [GROUPS];
    logic [GROUPS-1:0] live;
    logic [GRP_W-1:0]  newest_group;
    bit                newest_valid;
    logic [OFF_W:0]    fresh_offset;
    bit                hint_valid;
    logic [GRP_W-1:0]  hint_group;
    logic [OFF_W-1:0]  hint_offset;
    logic [CNT_W-1:0]  free_count;
    alloc_response_t   awaited [$];
    int                mismatches;
    int                no_slot_hits;

    function new();
      foreach (mask[g]) mask[g] = '1;
      live = '0;
      newest_group = '0;
      newest_valid = 1'b0;
      fresh_offset = (OFF_W + 1)'(SLOTS);
      hint_valid = 1'b0;
      hint_group = '0;
      hint_offset = '0;
      free_count = '0;
      mismatches = 0;
      no_slot_hits = 0;
    endfunction

    function void take_slot(int grp, int off, inout alloc_response_t rsp);
      mask[grp][off] = 1'b0;
      free_count = free_count - CNT_W'(1);
      rsp.grant_group = GRP_W'(grp);
      rsp.grant_offset = OFF_W'(off);
    endfunction

    function void note_request(req_type_t kind, logic [GRP_W-1:0] grp,
                               logic [OFF_W-1:0] off);
      alloc_response_t rsp;
      bit done;
      int fresh;
      rsp.status = ST_OK;
      rsp.grant_group = '0;
      rsp.grant_offset = '0;
      done = 1'b0;
      if (kind == REQ_ALLOC) begin
        if (hint_valid) begin
          hint_valid = 1'b0;
          if (live[hint_group] && mask[hint_group][hint_offset]) begin
            take_slot(int'(hint_group), int'(hint_offset), rsp);
            done = 1'b1;
          end
        end
        if (!done && newest_valid && fresh_offset < SLOTS && live[newest_group]) begin
          fresh = int'(fresh_offset);
          fresh_offset = fresh_offset + (OFF_W + 1)'(1);
          if (mask[newest_group][fresh]) begin
            take_slot(int'(newest_group), fresh, rsp);
            done = 1'b1;
          end
        end
        for (int g = 0; g < GROUPS && !done; g++) begin
          if (live[g] && mask[g] != '0) begin
            for (int b = 0; b < SLOTS && !done; b++) begin
              if (mask[g][b]) begin
                take_slot(g, b, rsp);
                done = 1'b1;
              end
            end
          end
        end
        for (int g = 0; g < GROUPS && !done; g++) begin
          if (!live[g]) begin
            live[g] = 1'b1;
            mask[g] = {{(SLOTS-1){1'b1}}, 1'b0};
            newest_group = GRP_W'(g);
            newest_valid = 1'b1;
            fresh_offset = (OFF_W + 1)'(1);
            free_count = free_count + CNT_W'(SLOTS - 1);
            rsp.grant_group = GRP_W'(g);
            done = 1'b1;
          end
        end
        if (!done) begin
          rsp.status = ST_NO_SLOT;
          no_slot_hits++;
        end
      end else if (!live[grp] || mask[grp][off]) begin
        rsp.status = ST_BAD_FREE;
      end else begin
        mask[grp][off] = 1'b1;
        if (mask[grp] == '1) begin
          live[grp] = 1'b0;
          free_count = free_count - CNT_W'(SLOTS - 1);
          hint_valid = 1'b0;
          if (grp == newest_group) begin
            newest_valid = 1'b0;
            fresh_offset = (OFF_W + 1)'(SLOTS);
          end
        end else begin
          free_count = free_count + CNT_W'(1);
          hint_valid = 1'b1;
          hint_group = grp;
          hint_offset = off;
        end
      end
      rsp.free_slots = free_count;
      awaited.push_back(rsp);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", what);
    endfunction

    function void check_response(status_t st, logic [GRP_W-1:0] grp,
                                 logic [OFF_W-1:0] off, logic [CNT_W-1:0] cnt);
      alloc_response_t exp;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected beat: status %0d group %0d offset %0d free %0d",
                       st, grp, off, cnt));
        return;
      end
      exp = awaited.pop_front();
      if (st !== exp.status)
        flag($sformatf("status: expected %0d, got %0d", exp.status, st));
      if (grp !== exp.grant_group)
        flag($sformatf("grant_group: expected %0d, got %0d", exp.grant_group, grp));
      if (off !== exp.grant_offset)
        flag($sformatf("grant_offset: expected %0d, got %0d", exp.grant_offset, off));
      if (cnt !== exp.free_slots)
        flag($sformatf("free_slots: expected %0d, got %0d", exp.free_slots, cnt));
    endfunction
  endclass

  logic clk;
  logic rst;
  idle_mode_t idle_mode;
  int cycles;
  slot_allocation_ledger board;

  gbsa_req_if req_bus ();
  gbsa_rsp_if rsp_bus ();

  grouped_bitmap_slot_allocator_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  initial clk = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("grouped_bitmap_slot_allocator_core regression: fail");
      $finish;
    end
  end

  function automatic int sender_idle_pct();
    case (idle_mode)
      SENDER_IDLE: return 83;
      BOTH_IDLE:   return 31;
      default:     return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (idle_mode)
      RECEIVER_STALL: return 83;
      BOTH_IDLE:      return 31;
      default:        return 0;
    endcase
  endfunction

  function automatic int pick_live_group(input bit lowest);
    int g;
    g = lowest ? 0 : int'($urandom_range(GROUPS - 1));
    for (int i = 0; i < GROUPS; i++) begin
      if (board.live[g]) return g;
      g = (g + 1) % GROUPS;
    end
    return g;
  endfunction

  function automatic logic [OFF_W-1:0] find_slot(input int grp, input bit want_free);
    logic [OFF_W-1:0] off;
    off = OFF_W'($urandom);
    for (int i = 0; i < SLOTS; i++) begin
      if (board.mask[grp][off] == want_free) return off;
      off = off + OFF_W'(1);
    end
    return off;
  endfunction

  task automatic send_request(input req_type_t kind, input logic [GRP_W-1:0] grp,
                              input logic [OFF_W-1:0] off);
    while ($urandom_range(99) < sender_idle_pct()) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid = 1'b1;
    req_bus.req_type = kind;
    req_bus.slot_group = grp;
    req_bus.slot_offset = off;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    board.note_request(kind, grp, off);
    @(negedge clk);
  endtask

  // Frees mostly target held slots, biased toward the lowest live group so that
  // groups drain and get released; a few hit already free slots or random ones.
  task automatic send_random_request(input int alloc_pct);
    req_type_t kind;
    logic [GRP_W-1:0] grp;
    logic [OFF_W-1:0] off;
    int roll;
    kind = REQ_ALLOC;
    grp = GRP_W'($urandom);
    off = OFF_W'($urandom);
    roll = $urandom_range(99);
    if (roll >= alloc_pct) begin
      kind = REQ_FREE;
      roll = $urandom_range(99);
      if (board.live != '0 && roll < 85) begin
        grp = GRP_W'(pick_live_group(roll < 45));
        off = find_slot(grp, 1'b0);
      end else if (board.live != '0 && roll < 93) begin
        grp = GRP_W'(pick_live_group(1'b0));
        off = find_slot(grp, 1'b1);
      end
    end
    send_request(kind, grp, off);
  endtask

  task automatic wait_for_responses();
    req_bus.valid = 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready)
        board.check_response(rsp_bus.status, rsp_bus.grant_group, rsp_bus.grant_offset,
                             rsp_bus.free_slots);
      @(negedge clk);
      rsp_bus.ready = ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  initial begin
    int n;
    board = new();
    cycles = 0;
    idle_mode = FLOW_FREE;
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_ALLOC;
    req_bus.slot_group = '0;
    req_bus.slot_offset = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Open a group, take fresh slots, reuse the freed slot, then hit every
    // flavor of bad free before releasing the only live group twice.
    send_request(REQ_ALLOC, 4'd0, 6'd0);
    send_request(REQ_ALLOC, 4'd0, 6'd0);
    send_request(REQ_ALLOC, 4'd0, 6'd0);
    send_request(REQ_FREE, 4'd0, 6'd1);
    send_request(REQ_ALLOC, 4'd0, 6'd0);
    send_request(REQ_FREE, 4'd0, 6'd1);
    send_request(REQ_FREE, 4'd0, 6'd1);
    send_request(REQ_FREE, 4'd5, 6'd10);
    send_request(REQ_FREE, 4'd15, 6'd63);
    send_request(REQ_FREE, 4'd0, 6'd63);
    send_request(REQ_ALLOC, 4'd0, 6'd0);
    send_request(REQ_ALLOC, 4'd15, 6'd63);
    send_request(REQ_FREE, 4'd0, 6'd0);
    send_request(REQ_FREE, 4'd0, 6'd1);
    send_request(REQ_FREE, 4'd0, 6'd2);
    send_request(REQ_FREE, 4'd0, 6'd3);
    send_request(REQ_FREE, 4'd0, 6'd0);
    send_request(REQ_ALLOC, 4'd0, 6'd0);
    send_request(REQ_FREE, 4'd0, 6'd0);
    send_request(REQ_ALLOC, 4'd0, 6'd0);

    for (n = 0; n < 120; n++) send_random_request(60);

    // Lean on allocation for a while, then on freeing so that groups drain.
    n = 0;
    while (board.no_slot_hits < 4 && n < 150) begin
      send_random_request(95);
      n++;
    end
    n = 0;
    while (board.live != '0 && n < 100) begin
      send_random_request(8);
      n++;
    end

    idle_mode = SENDER_IDLE;
    for (n = 0; n < 120; n++) send_random_request(55);
    wait_for_responses();
    idle_mode = RECEIVER_STALL;
    for (n = 0; n < 120; n++) send_random_request(50);
    idle_mode = BOTH_IDLE;
    for (n = 0; n < 120; n++) send_random_request(55);

    req_bus.valid = 1'b0;
    wait_for_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("grouped_bitmap_slot_allocator_core regression: pass");
    end else begin
      $display("grouped_bitmap_slot_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
